@@ sv/lsbse_pkg.sv @@
// Package for the LSB steganography embed/extract block.
// Holds the item and configuration types, register indexes and shared constants.
// No dependencies.
package lsbse_pkg;

	// Most message characters that extraction emits, and longest embeddable message.
	localparam int unsigned MAX_CHARS = 10;

	// Frame delimiter character.
	localparam logic [7:0] DELIM = 8'h24;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 3'd5;

	// Register reset values for the window.
	localparam logic [7:0] WIN_START_RST = 8'd33;
	localparam logic [7:0] WIN_END_RST   = 8'd120;

	// Mode encoding.
	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       char_valid;
		logic [7:0] char_out;
		logic       message_done;
		logic       end_of_file;
		logic       text_found;
	} out_item_t;

	typedef struct packed {
		logic        mode;
		logic [3:0]  message_length;
		logic [63:0] message_low;
		logic [15:0] message_high;
		logic [7:0]  window_start;
		logic [7:0]  window_end;
	} cfg_t;

	// Control handed from the top level to the embed and extract units.
	typedef struct packed {
		logic step;
		logic in_window;
		logic last;
	} step_ctl_t;

	// Extraction results for one item.
	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic       message_done;
		logic       text_found;
	} ext_res_t;

endpackage

@@ sv/lsbse_embed.sv @@
// Embed unit: frame bit counter and LSB replacement for one byte per cycle while the top level steps it.
// Depends on lsbse_pkg.
module lsbse_embed
	import lsbse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  step_ctl_t  ctl,
	input  logic [7:0] data_byte,
	output logic [7:0] out_byte
);

	logic [6:0] fbc_q;
	logic [7:0] frame_len;
	logic [3:0] char_idx;
	logic [3:0] msg_idx;
	logic [7:0] frame_char;
	logic [7:0] msg_char;
	logic       is_delim;
	logic       embed_now;

	// Frame length in bits is (length + 2) * 8, two delimiters around the text.
	assign frame_len = 8'(({4'd0, cfg.message_length} + 8'd2) << 3);

	// Character of the frame that holds the current bit.
	assign char_idx = fbc_q[6:3];
	assign msg_idx  = char_idx - 4'd1;
	assign is_delim = (char_idx == 4'd0) ||
		({1'b0, char_idx} == ({1'b0, cfg.message_length} + 5'd1));

	// Message character select; indexes past the stored ten read as zero.
	always_comb begin
		case (msg_idx)
			4'd0:    msg_char = cfg.message_low[63:56];
			4'd1:    msg_char = cfg.message_low[55:48];
			4'd2:    msg_char = cfg.message_low[47:40];
			4'd3:    msg_char = cfg.message_low[39:32];
			4'd4:    msg_char = cfg.message_low[31:24];
			4'd5:    msg_char = cfg.message_low[23:16];
			4'd6:    msg_char = cfg.message_low[15:8];
			4'd7:    msg_char = cfg.message_low[7:0];
			4'd8:    msg_char = cfg.message_high[15:8];
			4'd9:    msg_char = cfg.message_high[7:0];
			default: msg_char = 8'd0;
		endcase
	end

	assign frame_char = is_delim ? DELIM : msg_char;

	// A bit goes out while the frame lasts and the counter is below saturation.
	assign embed_now = (cfg.mode == MODE_EMBED) && ctl.in_window &&
		({1'b0, cfg.message_length} <= 5'(MAX_CHARS)) &&
		({1'b0, fbc_q} < frame_len) && (fbc_q != 7'h7f);

	// Frame bits go out MSB first.
	assign out_byte = embed_now ? {data_byte[7:1], frame_char[~fbc_q[2:0]]} : data_byte;

	// Frame bit counter, cleared after the last byte of a file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbc_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				fbc_q <= '0;
			end else if (embed_now) begin
				fbc_q <= fbc_q + 7'd1;
			end
		end
	end

endmodule

@@ sv/lsbse_extract.sv @@
// Extract unit: gathers window LSBs into characters and tracks the delimiters.
// Depends on lsbse_pkg.
module lsbse_extract
	import lsbse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      active,
	input  step_ctl_t ctl,
	input  logic      bit_in,
	output ext_res_t  res
);

	logic [7:0] acc_q,   acc_nx;
	logic [2:0] cnt_q,   cnt_nx;
	logic       start_q, start_nx;
	logic       stop_q,  stop_nx;
	logic [3:0] taken_q, taken_nx;
	logic [7:0] acc_shift;
	logic       take;

	assign take      = active && ctl.in_window && !stop_q;
	assign acc_shift = {acc_q[6:0], bit_in};

	// Next state and the per-item results.
	always_comb begin
		acc_nx   = acc_q;
		cnt_nx   = cnt_q;
		start_nx = start_q;
		stop_nx  = stop_q;
		taken_nx = taken_q;
		res      = '0;
		if (take) begin
			acc_nx = acc_shift;
			cnt_nx = cnt_q + 3'd1;
			// A full character has been gathered.
			if (cnt_q == 3'd7) begin
				if (!start_q) begin
					if (acc_shift == DELIM) begin
						start_nx = 1'b1;
					end
				end else if (acc_shift == DELIM) begin
					stop_nx          = 1'b1;
					res.message_done = 1'b1;
				end else if ({1'b0, taken_q} < 5'(MAX_CHARS)) begin
					res.char_valid = 1'b1;
					res.char_out   = acc_shift;
					taken_nx       = taken_q + 4'd1;
				end
				acc_nx = '0;
				cnt_nx = '0;
			end
		end
		res.text_found = active && ctl.last && start_nx && (taken_nx != 4'd0);
	end

	// Per-file state; all of it returns to zero after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			start_q <= 1'b0;
			stop_q  <= 1'b0;
			taken_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				acc_q   <= '0;
				cnt_q   <= '0;
				start_q <= 1'b0;
				stop_q  <= 1'b0;
				taken_q <= '0;
			end else begin
				acc_q   <= acc_nx;
				cnt_q   <= cnt_nx;
				start_q <= start_nx;
				stop_q  <= stop_nx;
				taken_q <= taken_nx;
			end
		end
	end

endmodule

@@ sv/lsb_stego_embed_extract.sv @@
// Top level of the LSB steganography embed/extract block.
// Depends on lsbse_pkg, lsbse_embed and lsbse_extract.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_item  (in_item_t)
// out       output     out_valid / out_ready out_item (out_item_t)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item accepted into the input register passes through the embed/extract logic into the result
// register when the stage advances, and its result is then offered on the out channel.
// One item is accepted per cycle while the result register is empty or being drained.
// Reset clears all per-file state and loads the register defaults; the window is 33..120.
// A stalled result holds the result register, and an empty input register takes one more item.
// The configuration port is always ready; writes are expected only while idle.
module lsb_stego_embed_extract
	import lsbse_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_s2;
	logic      valid_s2;
	logic [7:0] pos_q;
	logic      advance;
	step_ctl_t ctl;
	logic [7:0] emb_byte;
	ext_res_t  ext_res;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_EMBED;
			cfg_q.message_length <= '0;
			cfg_q.message_low    <= '0;
			cfg_q.message_high   <= '0;
			cfg_q.window_start   <= WIN_START_RST;
			cfg_q.window_end     <= WIN_END_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:      cfg_q.mode           <= cfg_data[0];
				CFG_MSG_LEN:   cfg_q.message_length <= cfg_data[3:0];
				CFG_MSG_LOW:   cfg_q.message_low    <= cfg_data;
				CFG_MSG_HIGH:  cfg_q.message_high   <= cfg_data[15:0];
				CFG_WIN_START: cfg_q.window_start   <= cfg_data[7:0];
				CFG_WIN_END:   cfg_q.window_end     <= cfg_data[7:0];
				default:       ;
			endcase
		end
	end

	// The stage advances whenever the result register is empty or being drained.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	assign ctl.step      = valid_s1 && advance;
	assign ctl.last      = item_s1.last_byte;
	assign ctl.in_window = (pos_q >= cfg_q.window_start) && (pos_q <= cfg_q.window_end);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (ctl.step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Byte position, saturating at the top and cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				pos_q <= '0;
			end else if (pos_q != 8'hff) begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

	lsbse_embed u_embed (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctl       (ctl),
		.data_byte (item_s1.data_byte),
		.out_byte  (emb_byte)
	);

	lsbse_extract u_extract (
		.clk    (clk),
		.arst_n (arst_n),
		.active (cfg_q.mode == MODE_EXTRACT),
		.ctl    (ctl),
		.bit_in (item_s1.data_byte[0]),
		.res    (ext_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.step) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			out_s2.out_byte     <= emb_byte;
			out_s2.char_valid   <= ext_res.char_valid;
			out_s2.char_out     <= ext_res.char_out;
			out_s2.message_done <= ext_res.message_done;
			out_s2.end_of_file  <= item_s1.last_byte;
			out_s2.text_found   <= ext_res.text_found;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = out_s2;

endmodule

@@ sv/lsbse_checker.sv @@
// Port-level checks for the LSB steganography embed/extract block.
// Depends on lsbse_pkg; bound to lsb_stego_embed_extract.
module lsbse_checker
	import lsbse_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// A stalled result item holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// With the result register empty the block always takes an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// Found is reported only on the last byte's result.
	a_found_at_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.text_found |-> out_item.end_of_file)
		else $error("text_found outside end of file");

	// A character and the closing delimiter never share one result, and char_out is zero without a character.
	a_char_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.char_valid && out_item.message_done) &&
			(out_item.char_valid || (out_item.char_out == 8'd0)))
		else $error("inconsistent character fields");

endmodule

bind lsb_stego_embed_extract lsbse_checker u_lsbse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lsb_stego_embed_extract: cover and stego files in both modes.
// Depends on lsbse_pkg and the block's top level; the scoreboard class predicts every result.

module tb;
	import lsbse_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned ITEM_TARGET    = 1550;
	localparam int unsigned LONG_HOLD      = 150;
	localparam int unsigned MAX_REPORTS    = 20;

	// Indexes past the last register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	// Predicts the block from its own copy of the registers and per-file state.
	class stego_scoreboard;
		logic        mode;
		logic [3:0]  msg_len;
		logic [63:0] msg_low;
		logic [15:0] msg_high;
		logic [7:0]  win_start;
		logic [7:0]  win_end;

		logic [7:0]  position;
		logic [6:0]  frame_bits;
		logic [7:0]  char_acc;
		logic [2:0]  char_bits;
		bit          start_seen;
		bit          stop_seen;
		logic [3:0]  chars_taken;

		out_item_t   expected_q[$];
		int unsigned n_errors;
		int unsigned n_checked;
		int unsigned n_chars;
		int unsigned n_done;
		int unsigned n_found;

		function new();
			mode      = MODE_EMBED;
			msg_len   = '0;
			msg_low   = '0;
			msg_high  = '0;
			win_start = WIN_START_RST;
			win_end   = WIN_END_RST;
			clear_file();
			n_errors  = 0;
			n_checked = 0;
			n_chars   = 0;
			n_done    = 0;
			n_found   = 0;
		endfunction

		function void clear_file();
			position    = '0;
			frame_bits  = '0;
			char_acc    = '0;
			char_bits   = '0;
			start_seen  = 1'b0;
			stop_seen   = 1'b0;
			chars_taken = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
			case (idx)
				CFG_MODE:      mode      = value[0];
				CFG_MSG_LEN:   msg_len   = value[3:0];
				CFG_MSG_LOW:   msg_low   = value;
				CFG_MSG_HIGH:  msg_high  = value[15:0];
				CFG_WIN_START: win_start = value[7:0];
				CFG_WIN_END:   win_end   = value[7:0];
				default: ;
			endcase
		endfunction

		// Characters past the stored ten read as zero.
		function logic [7:0] msg_char(int unsigned idx);
			if (idx < 8)
				return msg_low[63 - 8 * idx -: 8];
			if (idx == 8)
				return msg_high[15:8];
			if (idx == 9)
				return msg_high[7:0];
			return 8'h00;
		endfunction

		// Bit k of the frame '$' + text + '$', MSB first within each character.
		function logic frame_bit(int unsigned k);
			int unsigned c;
			logic [7:0] ch;
			c = k >> 3;
			if (c == 0 || c == int'(msg_len) + 1)
				ch = DELIM;
			else
				ch = msg_char(c - 1);
			return ch[7 - (k & 7)];
		endfunction

		function void note_input(in_item_t it);
			out_item_t   e;
			bit          in_win;
			int unsigned frame_len;
			e = '0;
			e.out_byte    = it.data_byte;
			e.end_of_file = it.last_byte;
			in_win = (position >= win_start) && (position <= win_end);
			if (mode == MODE_EMBED) begin
				// Replace the LSB while frame bits remain and the length is storable.
				if (in_win && msg_len <= MAX_CHARS) begin
					frame_len = (int'(msg_len) + 2) * 8;
					if (frame_bits < frame_len && frame_bits < 127) begin
						e.out_byte = {it.data_byte[7:1], frame_bit(int'(frame_bits))};
						frame_bits++;
					end
				end
			end else begin
				// Gather LSBs into characters until the closing delimiter.
				if (in_win && !stop_seen) begin
					char_acc = {char_acc[6:0], it.data_byte[0]};
					if (char_bits == 3'd7) begin
						if (!start_seen) begin
							if (char_acc == DELIM)
								start_seen = 1'b1;
						end else if (char_acc == DELIM) begin
							stop_seen      = 1'b1;
							e.message_done = 1'b1;
						end else if (chars_taken < MAX_CHARS) begin
							e.char_valid = 1'b1;
							e.char_out   = char_acc;
							chars_taken++;
						end
						char_acc  = '0;
						char_bits = '0;
					end else begin
						char_bits++;
					end
				end
				if (it.last_byte)
					e.text_found = start_seen && (chars_taken != 0);
			end
			if (position != 8'hFF)
				position++;
			if (it.last_byte)
				clear_file();
			expected_q.push_back(e);
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (got_v !== exp_v) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: %s expected %h, got %h", $time, name, exp_v, got_v);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: result %h arrived with nothing expected, expected none",
						$time, got);
				return;
			end
			e = expected_q.pop_front();
			n_checked++;
			if (e.char_valid)
				n_chars++;
			if (e.message_done)
				n_done++;
			if (e.text_found)
				n_found++;
			compare_field("out_byte", e.out_byte, got.out_byte);
			compare_field("char_valid", 8'(e.char_valid), 8'(got.char_valid));
			compare_field("char_out", e.char_out, got.char_out);
			compare_field("message_done", 8'(e.message_done), 8'(got.message_done));
			compare_field("end_of_file", 8'(e.end_of_file), 8'(got.end_of_file));
			compare_field("text_found", 8'(e.text_found), 8'(got.text_found));
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data  = '0;

	stego_scoreboard sb = new();

	int unsigned burst_left   = 0;
	int unsigned items_sent   = 0;
	int unsigned setting_cnt  = 0;
	bit          hidden_bits[$];

	always #5 clk = ~clk;

	lsb_stego_embed_extract i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Every handshake is observed at the clock edge that completes it.
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
		if (out_valid && out_ready)
			sb.check_result(out_item);
		if (in_valid && in_ready)
			sb.note_input(in_item);
	end

	// Receiver: a stall pattern selected by upper bits of a free-running cycle counter, and two long hold-offs.
	int unsigned rx_hold    = 0;
	int unsigned rx_results = 0;
	int unsigned holds_done = 0;
	logic [31:0] rx_cycle   = '0;
	logic        hold_due;

	assign hold_due = (holds_done == 0 && rx_results >= 200) ||
		(holds_done == 1 && rx_results >= 900);

	always @(posedge clk) begin
		if (out_valid && out_ready)
			rx_results++;
		rx_cycle++;
		if (rx_hold != 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (hold_due && in_valid) begin
			holds_done++;
			rx_hold = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_cycle[8:6])
				3'd0, 3'd1: out_ready <= 1'b1;
				3'd2:       out_ready <= ($urandom_range(0, 3) == 0);
				default:    out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Watchdog on cycles with no handshake on any channel.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, sb.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one file byte; bursts of random length are separated by random gaps.
	task automatic send_item(input logic [7:0] data, input logic is_last);
		int unsigned gap;
		in_item_t    it;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		it.data_byte = data;
		it.last_byte = is_last;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic m, input logic [3:0] len, input logic [63:0] lo,
		input logic [15:0] hi, input logic [7:0] ws, input logic [7:0] we);
		write_reg(CFG_MODE, {63'd0, m});
		write_reg(CFG_MSG_LEN, {60'd0, len});
		write_reg(CFG_MSG_LOW, lo);
		write_reg(CFG_MSG_HIGH, {48'd0, hi});
		write_reg(CFG_WIN_START, {56'd0, ws});
		write_reg(CFG_WIN_END, {56'd0, we});
		setting_cnt++;
	endtask

	// Stops offering and waits until every predicted result has been taken.
	task automatic settle();
		if (in_valid)
			in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] ch;
		ch = 8'($urandom);
		if (ch == DELIM)
			ch ^= 8'h01;
		return ch;
	endfunction

	task automatic push_char(input logic [7:0] ch);
		for (int b = 7; b >= 0; b--)
			hidden_bits.push_back(ch[b]);
	endtask

	// Hidden content for an extract file: mostly well-formed frames, some broken or none.
	task automatic build_frame();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			repeat ($urandom_range(0, 2)) push_char(plain_char());
			push_char(DELIM);
			repeat ($urandom_range(0, 12)) push_char(plain_char());
			if ($urandom_range(0, 99) < 85)
				push_char(DELIM);
		end else if (pick < 85) begin
			// Off by a few bits, so the delimiters fall across character boundaries.
			repeat ($urandom_range(1, 7)) hidden_bits.push_back(1'($urandom_range(0, 1)));
			push_char(DELIM);
			repeat ($urandom_range(1, 4)) push_char(plain_char());
			push_char(DELIM);
		end
	endtask

	// Sends one file; window bytes carry the queued hidden bits in their LSBs.
	task automatic send_file(input int unsigned len, input bit cut);
		logic [7:0] pos;
		logic [7:0] data;
		for (int unsigned i = 0; i < len; i++) begin
			pos  = (i < 255) ? i[7:0] : 8'hFF;
			data = 8'($urandom);
			if (pos >= sb.win_start && pos <= sb.win_end && hidden_bits.size() != 0)
				data[0] = hidden_bits.pop_front();
			send_item(data, (i == len - 1) && !cut);
		end
		hidden_bits.delete();
	endtask

	task automatic random_phase();
		logic        m;
		logic [3:0]  len;
		logic [7:0]  ws;
		logic [7:0]  we;
		int unsigned pick;
		int unsigned files;
		int unsigned flen;
		bit          cut;
		m   = ($urandom_range(0, 99) < 55) ? MODE_EXTRACT : MODE_EMBED;
		len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15)) :
			4'($urandom_range(0, 10));
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			ws = 8'd0;
			we = 8'd255;
		end else if (pick < 10) begin
			ws = 8'd255;
			we = 8'd255;
		end else if (pick < 16) begin
			ws = 8'($urandom_range(40, 200));
			we = 8'($urandom_range(0, ws - 1));
		end else if (pick < 22) begin
			ws = WIN_START_RST;
			we = WIN_END_RST;
		end else if (pick < 26) begin
			ws = 8'($urandom_range(0, 40));
			we = ws;
		end else begin
			ws = 8'($urandom_range(0, 24));
			we = 8'(ws + $urandom_range(16, 110));
		end
		apply_setting(m, len, {$urandom, $urandom}, 16'($urandom), ws, we);

		files = (we >= 200) ? 1 : $urandom_range(1, 3);
		for (int unsigned f = 0; f < files; f++) begin
			if (m == MODE_EXTRACT)
				build_frame();
			if (we < ws) begin
				flen = $urandom_range(1, 40);
			end else if (we == 8'd255) begin
				// Runs past position 255 so the position counter saturates.
				flen = 256 + $urandom_range(2, 30);
			end else begin
				flen = we + 1 + $urandom_range(0, 8);
				if ($urandom_range(0, 4) == 0)
					flen = $urandom_range(1, flen);
			end
			// Now and then the file stops short; the next setting continues it.
			cut = (f == files - 1) && ($urandom_range(0, 6) == 0);
			send_file(flen, cut);
		end
		settle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: the reset window starts past this short file.
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		settle();

		// Writes above the last register index change nothing.
		write_reg(CFG_SPARE_A, {$urandom, $urandom});
		write_reg(CFG_SPARE_B, {$urandom, $urandom});

		// Empty message, frame cut off by the window end; extreme byte values.
		apply_setting(MODE_EMBED, 4'd0, '1, '1, 8'd0, 8'd4);
		for (int i = 0; i < 6; i++)
			send_item(i[0] ? 8'hFF : 8'h00, i == 5);
		settle();

		// Message length too long: bytes pass through.
		apply_setting(MODE_EMBED, 4'd15, {$urandom, $urandom}, '0, 8'd0, 8'd3);
		for (int i = 0; i < 3; i++)
			send_item(8'hFF, i == 2);
		settle();

		// Inverted window: nothing is carried.
		apply_setting(MODE_EMBED, 4'd10, {$urandom, $urandom}, 16'($urandom), 8'd200, 8'd100);
		for (int i = 0; i < 3; i++)
			send_item(8'h00, i == 2);
		settle();

		// Opening delimiter with no text: no text found at end of file.
		apply_setting(MODE_EXTRACT, 4'd0, '0, '0, 8'd2, 8'd9);
		push_char(DELIM);
		send_file(12, 1'b0);
		settle();

		while (items_sent < ITEM_TARGET)
			random_phase();

		repeat (8) @(posedge clk);
		$display("Sent %0d file bytes under %0d register settings; checked %0d results.",
			items_sent, setting_cnt, sb.n_checked);
		$display("Extracted %0d characters, %0d closing delimiters, %0d files with text.",
			sb.n_chars, sb.n_done, sb.n_found);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.n_errors, sb.pending());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/lsbse_pkg.sv
sv/lsbse_embed.sv
sv/lsbse_extract.sv
sv/lsb_stego_embed_extract.sv
sv/lsbse_checker.sv
tb/tb.sv
